### design/tsc_pkg.sv
package tsc_pkg;

   // port field widths
   localparam int ANGLE_W    = 16;
   localparam int COUNT_W    = 4;
   localparam int OUT_W      = 24;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // internal widths
   localparam int TERM_W    = 3;   // clamped term count, up to six
   localparam int WORK_BITS = 26;  // fraction bits of x, terms and sums
   localparam int X_W       = 29;  // x in radians, up to 2*pi
   localparam int MAG_W     = 34;  // term magnitude
   localparam int V_W       = 37;  // rounded product before the divide by k
   localparam int ACC_W     = 40;  // signed running sums
   localparam int DEG_W     = 9;   // reduced angle, 0 to 360

   // angle reduction: q = (deg * MOD_RECIP) >> MOD_SHIFT is deg / 360 exactly
   localparam int          FULL_TURN = 360;
   localparam int          MOD_PROD_W = 32;
   localparam int          MOD_SHIFT = 24;
   localparam logic [15:0] MOD_RECIP = 16'd46604;

   // degrees to radians with pi as 3.14:
   // x = deg * RAD_WHOLE + ((deg * RAD_PART + RAD_BIAS) >> 4) / 1125
   localparam logic [20:0] RAD_WHOLE     = 21'd1170676;
   localparam logic [13:0] RAD_PART      = 14'd15296;
   localparam int          RAD_BIAS      = 9000;
   localparam int          RAD_V_W       = 23;
   localparam int          RAD_PRE_SHIFT = 4;
   localparam int          RAD_W_W       = 19;
   localparam logic [19:0] RAD_RECIP     = 20'd954438;
   localparam int          RAD_SHIFT     = 30;
   localparam int          RAD_PROD_W    = 39;

   // one item travelling along the row of cells
   typedef struct packed {
      logic [TERM_W-1:0]       term_count;
      logic [X_W-1:0]          x;
      logic [MAG_W-1:0]        mag;
      logic signed [ACC_W-1:0] sin_acc;
      logic signed [ACC_W-1:0] cos_acc;
   } tsc_token_type;

   // term number idx takes part when it is below twice the term count
   function automatic logic term_used(input logic [TERM_W-1:0] n, input int idx);
      return {n, 1'b0} > (TERM_W + 1)'(idx);
   endfunction

   // add or subtract one term magnitude
   function automatic logic signed [ACC_W-1:0] add_term(
      input logic signed [ACC_W-1:0] acc,
      input logic [MAG_W-1:0]        mag,
      input logic                    neg
   );
      logic signed [ACC_W-1:0] t;
      t = signed'({{(ACC_W - MAG_W){1'b0}}, mag});
      return neg ? acc - t : acc + t;
   endfunction

endpackage

### design/tsc_front.sv
module tsc_front import tsc_pkg::*; #(
   parameter int MAX_TERMS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [ANGLE_W-1:0]   angle_degrees,
   input  logic [COUNT_W-1:0]   term_count,
   output logic                 out_valid,
   output tsc_token_type        out_tok
);

   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic [MOD_PROD_W-1:0]   s1_prod_ff, s1_prod_in;
   logic [ANGLE_W-1:0]      s1_deg_ff;
   logic [TERM_W-1:0]       s1_n_ff, s1_n_in;
   logic [DEG_W-1:0]        s2_deg_ff, s2_deg_in;
   logic [TERM_W-1:0]       s2_n_ff;
   logic [X_W-1:0]          s3_xa_ff, s3_xa_in;
   logic [RAD_W_W-1:0]      s3_w_ff, s3_w_in;
   logic [TERM_W-1:0]       s3_n_ff;
   logic [RAD_PROD_W-1:0]   s4_recip_ff, s4_recip_in;
   logic [X_W-1:0]          s4_xa_ff;
   logic [TERM_W-1:0]       s4_n_ff;
   tsc_token_type           s5_tok_ff, s5_tok_in;
   logic [ANGLE_W-1:0]      quot;
   logic [ANGLE_W-1:0]      rem;
   logic [RAD_V_W-1:0]      rad_v;

   // clamp term count and start the divide by 360
   always_comb begin
      s1_n_in    = (term_count > COUNT_W'(MAX_TERMS)) ? TERM_W'(MAX_TERMS)
                                                      : term_count[TERM_W-1:0];
      s1_prod_in = MOD_PROD_W'(angle_degrees) * MOD_PROD_W'(MOD_RECIP);
   end

   // reduce above one full turn, 360 itself stays
   always_comb begin
      quot      = ANGLE_W'(s1_prod_ff[MOD_PROD_W-1:MOD_SHIFT]);
      rem       = s1_deg_ff - quot * ANGLE_W'(FULL_TURN);
      s2_deg_in = (s1_deg_ff > ANGLE_W'(FULL_TURN)) ? rem[DEG_W-1:0] : s1_deg_ff[DEG_W-1:0];
   end

   // whole and partial parts of the radian conversion
   always_comb begin
      s3_xa_in = X_W'(s2_deg_ff) * X_W'(RAD_WHOLE);
      rad_v    = RAD_V_W'(s2_deg_ff) * RAD_V_W'(RAD_PART) + RAD_V_W'(RAD_BIAS);
      s3_w_in  = rad_v[RAD_V_W-1:RAD_PRE_SHIFT];
   end

   // divide the partial part by 1125 through its reciprocal
   assign s4_recip_in = RAD_PROD_W'(s3_w_ff) * RAD_PROD_W'(RAD_RECIP);

   // x complete, first term is one
   always_comb begin
      s5_tok_in.term_count = s4_n_ff;
      s5_tok_in.x          = s4_xa_ff + X_W'(s4_recip_ff[RAD_PROD_W-1:RAD_SHIFT]);
      s5_tok_in.mag        = MAG_W'(1) << WORK_BITS;
      s5_tok_in.sin_acc    = '0;
      s5_tok_in.cos_acc    = '0;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff  <= s1_prod_in;
         s1_deg_ff   <= angle_degrees;
         s1_n_ff     <= s1_n_in;
         s2_deg_ff   <= s2_deg_in;
         s2_n_ff     <= s1_n_ff;
         s3_xa_ff    <= s3_xa_in;
         s3_w_ff     <= s3_w_in;
         s3_n_ff     <= s2_n_ff;
         s4_recip_ff <= s4_recip_in;
         s4_xa_ff    <= s3_xa_ff;
         s4_n_ff     <= s3_n_ff;
         s5_tok_ff   <= s5_tok_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_tok   = s5_tok_ff;

endmodule

### design/tsc_cell.sv
module tsc_cell import tsc_pkg::*; #(
   parameter int STEP = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  tsc_token_type in_tok,
   output logic          out_valid,
   output tsc_token_type out_tok
);

   // the incoming magnitude is term STEP-1, the outgoing one term STEP
   localparam int   TERM_IDX = STEP - 1;
   localparam logic TERM_SIN = (TERM_IDX % 2) == 1;
   localparam logic TERM_NEG = ((TERM_IDX / 2) % 2) == 1;

   // split of mag * x into two partial products
   localparam int MAG_LO   = MAG_W / 2;
   localparam int MAG_HI_W = MAG_W - MAG_LO;
   localparam int PP1_W    = MAG_HI_W + X_W;
   localparam int PROD_W   = MAG_W + X_W;

   // divide by STEP as v * floor(2^V_W / STEP) >> V_W, then one correction
   localparam int                 RECIP_W = V_W + 1;
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << V_W) / STEP);
   localparam int                 V_LO    = V_W / 2;
   localparam int                 V_HI_W  = V_W - V_LO;
   localparam int                 R_LO    = RECIP_W / 2;
   localparam int                 R_HI_W  = RECIP_W - R_LO;
   localparam int                 PP2_W   = V_HI_W + R_HI_W;
   localparam int                 FULL_W  = V_W + RECIP_W;
   localparam int                 HALF_STEP = STEP / 2;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   tsc_token_type        s1_tok_ff, s1_tok_in;
   logic [PP1_W-1:0]     s1_pp_hi_ff, s1_pp_hi_in;
   logic [PP1_W-1:0]     s1_pp_lo_ff, s1_pp_lo_in;
   tsc_token_type        s2_tok_ff;
   logic [V_W-1:0]       s2_v_ff, s2_v_in;
   tsc_token_type        s3_tok_ff;
   logic [V_W-1:0]       s3_v_ff;
   logic [PP2_W-1:0]     s3_hh_ff, s3_hl_ff, s3_lh_ff, s3_ll_ff;
   logic [PP2_W-1:0]     s3_hh_in, s3_hl_in, s3_lh_in, s3_ll_in;
   tsc_token_type        s4_tok_ff;
   logic [V_W-1:0]       s4_v_ff;
   logic [V_W-1:0]       s4_q0_ff, s4_q0_in;
   tsc_token_type        s5_tok_ff, s5_tok_in;
   logic [PROD_W-1:0]    prod;
   logic [PROD_W-1:0]    prod_rnd;
   logic [FULL_W-1:0]    full;
   logic [V_W-1:0]       rem;
   logic [V_W-1:0]       quot;

   // add the incoming term and multiply it by x in two halves
   always_comb begin
      s1_tok_in = in_tok;
      if (term_used(in_tok.term_count, TERM_IDX)) begin
         if (TERM_SIN) begin
            s1_tok_in.sin_acc = add_term(in_tok.sin_acc, in_tok.mag, TERM_NEG);
         end else begin
            s1_tok_in.cos_acc = add_term(in_tok.cos_acc, in_tok.mag, TERM_NEG);
         end
      end
      s1_pp_hi_in = PP1_W'(in_tok.mag[MAG_W-1:MAG_LO]) * PP1_W'(in_tok.x);
      s1_pp_lo_in = PP1_W'(in_tok.mag[MAG_LO-1:0]) * PP1_W'(in_tok.x);
   end

   // join the halves, round off the work fraction, add STEP/2 for rounding
   always_comb begin
      prod     = (PROD_W'(s1_pp_hi_ff) << MAG_LO) + PROD_W'(s1_pp_lo_ff);
      prod_rnd = (prod + (PROD_W'(1) << (WORK_BITS - 1))) >> WORK_BITS;
      s2_v_in  = V_W'(prod_rnd) + V_W'(HALF_STEP);
   end

   // partial products of v times the reciprocal
   always_comb begin
      s3_hh_in = PP2_W'(s2_v_ff[V_W-1:V_LO]) * PP2_W'(RECIP[RECIP_W-1:R_LO]);
      s3_hl_in = PP2_W'(s2_v_ff[V_W-1:V_LO]) * PP2_W'(RECIP[R_LO-1:0]);
      s3_lh_in = PP2_W'(s2_v_ff[V_LO-1:0]) * PP2_W'(RECIP[RECIP_W-1:R_LO]);
      s3_ll_in = PP2_W'(s2_v_ff[V_LO-1:0]) * PP2_W'(RECIP[R_LO-1:0]);
   end

   // quotient estimate, at most one short
   always_comb begin
      full     = (FULL_W'(s3_hh_ff) << (V_LO + R_LO)) + (FULL_W'(s3_hl_ff) << V_LO)
               + (FULL_W'(s3_lh_ff) << R_LO) + FULL_W'(s3_ll_ff);
      s4_q0_in = V_W'(full >> V_W);
   end

   // correct the estimate and hand the new term on
   always_comb begin
      rem       = s4_v_ff - s4_q0_ff * V_W'(STEP);
      quot      = (rem >= V_W'(STEP)) ? s4_q0_ff + V_W'(1) : s4_q0_ff;
      s5_tok_in = s4_tok_ff;
      s5_tok_in.mag = MAG_W'(quot);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_tok_ff   <= s1_tok_in;
         s1_pp_hi_ff <= s1_pp_hi_in;
         s1_pp_lo_ff <= s1_pp_lo_in;
         s2_tok_ff   <= s1_tok_ff;
         s2_v_ff     <= s2_v_in;
         s3_tok_ff   <= s2_tok_ff;
         s3_v_ff     <= s2_v_ff;
         s3_hh_ff    <= s3_hh_in;
         s3_hl_ff    <= s3_hl_in;
         s3_lh_ff    <= s3_lh_in;
         s3_ll_ff    <= s3_ll_in;
         s4_tok_ff   <= s3_tok_ff;
         s4_v_ff     <= s3_v_ff;
         s4_q0_ff    <= s4_q0_in;
         s5_tok_ff   <= s5_tok_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_tok   = s5_tok_ff;

endmodule

### design/tsc_out.sv
module tsc_out import tsc_pkg::*; #(
   parameter int MAX_TERMS = 6,
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  tsc_token_type    in_tok,
   output logic             out_valid,
   output logic [OUT_W-1:0] sine_value,
   output logic [OUT_W-1:0] cosine_value
);

   // last term of the longest series, not yet added by any cell
   localparam int   LAST_IDX = 2 * MAX_TERMS - 1;
   localparam logic LAST_SIN = (LAST_IDX % 2) == 1;
   localparam logic LAST_NEG = ((LAST_IDX / 2) % 2) == 1;

   // rounding to the output fraction
   localparam int               SHIFT   = WORK_BITS - FRAC_BITS;
   localparam logic [ACC_W:0]   HALF    = ((ACC_W + 1)'(1) << SHIFT) >> 1;
   localparam logic [ACC_W:0]   NEG_LIM = (ACC_W + 1)'(1) << (OUT_W - 1);
   localparam logic [ACC_W:0]   POS_LIM = NEG_LIM - (ACC_W + 1)'(1);

   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [ACC_W-1:0] s1_sin_ff, s1_sin_in, s1_cos_ff, s1_cos_in;
   logic [ACC_W-1:0]        s2_sin_mag_ff, s2_sin_mag_in, s2_cos_mag_ff, s2_cos_mag_in;
   logic                    s2_sin_neg_ff, s2_cos_neg_ff;
   logic [OUT_W-1:0]        s3_sin_ff, s3_sin_in, s3_cos_ff, s3_cos_in;

   // round half away from zero and saturate
   function automatic logic [OUT_W-1:0] to_out(input logic [ACC_W-1:0] mag, input logic neg);
      logic [ACC_W:0] r;
      r = ((ACC_W + 1)'(mag) + HALF) >> SHIFT;
      if (neg) begin
         if (r > NEG_LIM) begin
            r = NEG_LIM;
         end
         return OUT_W'(-r);
      end
      if (r > POS_LIM) begin
         r = POS_LIM;
      end
      return OUT_W'(r);
   endfunction

   // final term
   always_comb begin
      s1_sin_in = in_tok.sin_acc;
      s1_cos_in = in_tok.cos_acc;
      if (term_used(in_tok.term_count, LAST_IDX)) begin
         if (LAST_SIN) begin
            s1_sin_in = add_term(in_tok.sin_acc, in_tok.mag, LAST_NEG);
         end else begin
            s1_cos_in = add_term(in_tok.cos_acc, in_tok.mag, LAST_NEG);
         end
      end
   end

   // sign and magnitude
   always_comb begin
      s2_sin_mag_in = s1_sin_ff[ACC_W-1] ? ACC_W'(-s1_sin_ff) : ACC_W'(s1_sin_ff);
      s2_cos_mag_in = s1_cos_ff[ACC_W-1] ? ACC_W'(-s1_cos_ff) : ACC_W'(s1_cos_ff);
   end

   // output format
   always_comb begin
      s3_sin_in = to_out(s2_sin_mag_ff, s2_sin_neg_ff);
      s3_cos_in = to_out(s2_cos_mag_ff, s2_cos_neg_ff);
   end

   // valid bits, the last one is the response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_sin_ff     <= s1_sin_in;
         s1_cos_ff     <= s1_cos_in;
         s2_sin_mag_ff <= s2_sin_mag_in;
         s2_cos_mag_ff <= s2_cos_mag_in;
         s2_sin_neg_ff <= s1_sin_ff[ACC_W-1];
         s2_cos_neg_ff <= s1_cos_ff[ACC_W-1];
         s3_sin_ff     <= s3_sin_in;
         s3_cos_ff     <= s3_cos_in;
      end
   end

   assign out_valid    = s3_valid_ff;
   assign sine_value   = s3_sin_ff;
   assign cosine_value = s3_cos_ff;

endmodule

### design/taylor_sine_cosine_degrees.sv
// the pipeline has five register stages in each of the 2 * MAX_TERMS - 1 term cells
// plus five stages of angle reduction and three of output rounding
// throughput: one request per cycle; the whole pipeline holds while a
// response waits on rsp_tready
// reset: synchronous, clears every valid bit; nothing else to clear
module taylor_sine_cosine_degrees import tsc_pkg::*; #(
   parameter int MAX_TERMS = 6,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // angle_degrees[15:0], term_count[19:16], zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // sine_value[23:0], cosine_value[47:24]
);

   localparam int NUM_CELLS = 2 * MAX_TERMS - 1;

   logic             pipe_en;
   logic             chain_valid [NUM_CELLS+1];
   tsc_token_type    chain_tok   [NUM_CELLS+1];
   logic [OUT_W-1:0] sine_value;
   logic [OUT_W-1:0] cosine_value;

   // everything moves unless a response is held
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en && !reset;

   // angle reduction and conversion to radians
   tsc_front #(
      .MAX_TERMS (MAX_TERMS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (pipe_en),
      .in_valid      (req_tvalid && req_tready),
      .angle_degrees (req_tdata[ANGLE_W-1:0]),
      .term_count    (req_tdata[ANGLE_W+COUNT_W-1:ANGLE_W]),
      .out_valid     (chain_valid[0]),
      .out_tok       (chain_tok[0])
   );

   // row of term cells
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      tsc_cell #(
         .STEP (g + 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (chain_valid[g]),
         .in_tok    (chain_tok[g]),
         .out_valid (chain_valid[g+1]),
         .out_tok   (chain_tok[g+1])
      );
   end

   // last term, rounding and saturation
   tsc_out #(
      .MAX_TERMS (MAX_TERMS),
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock        (clock),
      .reset        (reset),
      .en           (pipe_en),
      .in_valid     (chain_valid[NUM_CELLS]),
      .in_tok       (chain_tok[NUM_CELLS]),
      .out_valid    (rsp_tvalid),
      .sine_value   (sine_value),
      .cosine_value (cosine_value)
   );

   assign rsp_tdata = {cosine_value, sine_value};

endmodule

### design/tsc_checker.sv
module tsc_checker import tsc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // no response straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a held response keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held response changed");

   // a held response stalls the request side
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response held");

   // with no response waiting the block takes requests
   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

   // a refused request stays offered with the same data
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("waiting request changed");

endmodule

bind taylor_sine_cosine_degrees tsc_checker u_tsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tsc_pkg::*;

   // predictor arithmetic
   localparam int SERIES_MAX   = 6;     // term count clamp
   localparam int WORK_FRAC    = 26;    // fraction bits of x, terms and sums
   localparam int OUT_FRAC     = 16;    // fraction bits of the outputs
   localparam int TURN_DEG     = 360;
   localparam int RANDOM_ITEMS = 650;
   localparam int DRAIN_CYCLES = 100;
   localparam int TIMEOUT_NS   = 2000000;
   localparam int DIRECTED_ROWS = 24;

   typedef struct packed {
      logic signed [OUT_W-1:0] sine;
      logic signed [OUT_W-1:0] cosine;
   } trig_pair_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [COUNT_W-1:0] terms;
      logic               literal;   // expected values typed in below
      trig_pair_type      pair;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // angle_degrees[15:0], term_count[19:16], zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // sine_value[23:0], cosine_value[47:24]

   trig_pair_type trig_expected_q[$];
   int            fail_count = 0;
   logic          steady = 1'b0;   // no idling on either side while set

   // directed stimulus: zero terms, zero angle, clamps, wrap-around, extremes
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'd0,     4'd0,  1'b1, '{24'sd0, 24'sd0}},
      '{16'd65535, 4'd0,  1'b1, '{24'sd0, 24'sd0}},
      '{16'd360,   4'd0,  1'b1, '{24'sd0, 24'sd0}},
      '{16'd0,     4'd1,  1'b1, '{24'sd0, 24'sd65536}},
      '{16'd0,     4'd15, 1'b1, '{24'sd0, 24'sd65536}},
      '{16'd720,   4'd6,  1'b1, '{24'sd0, 24'sd65536}},
      '{16'd0,     4'd6,  1'b1, '{24'sd0, 24'sd65536}},
      '{16'd360,   4'd6,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd361,   4'd6,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd65535, 4'd15, 1'b0, '{24'sd0, 24'sd0}},
      '{16'd65535, 4'd6,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd180,   4'd6,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd90,    4'd1,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd90,    4'd2,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd90,    4'd3,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd90,    4'd4,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd90,    4'd5,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd90,    4'd6,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd90,    4'd7,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd359,   4'd6,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd1,     4'd6,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd270,   4'd15, 1'b0, '{24'sd0, 24'sd0}},
      '{16'd45,    4'd3,  1'b0, '{24'sd0, 24'sd0}},
      '{16'd32768, 4'd9,  1'b0, '{24'sd0, 24'sd0}}
   };

   taylor_sine_cosine_degrees u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // round a work-precision sum to the output format, ties away from zero
   function automatic logic [OUT_W-1:0] round_to_q8_16(input logic signed [63:0] v);
      logic [63:0] mag;
      int unsigned shift;
      mag   = (v < 0) ? 64'(-v) : 64'(v);
      shift = WORK_FRAC - OUT_FRAC;
      mag   = (mag + ((64'd1 << shift) >> 1)) >> shift;
      if (v < 0) begin
         if (mag > 64'd8388608) mag = 64'd8388608;
         return OUT_W'(64'd0 - mag);
      end
      if (mag > 64'd8388607) mag = 64'd8388607;
      return OUT_W'(mag);
   endfunction

   // truncated taylor sums of sine and cosine for one request
   function automatic trig_pair_type taylor_sin_cos(input logic [ANGLE_W-1:0] angle,
                                                    input logic [COUNT_W-1:0] terms);
      logic [63:0]        deg, x, mag, prod;
      logic signed [63:0] sin_sum, cos_sum;
      int unsigned        n;
      trig_pair_type      res;
      n = (terms > SERIES_MAX) ? SERIES_MAX : terms;
      deg = 64'(angle);
      if (deg > TURN_DEG) deg = deg % TURN_DEG;
      x = (((deg * 64'd314) << WORK_FRAC) + 64'd9000) / 64'd18000;
      mag = 64'd1 << WORK_FRAC;
      sin_sum = 0;
      cos_sum = 0;
      for (int unsigned k = 0; k < 2 * n; k++) begin
         // each power term from the previous one, rounded at every step
         if (k > 0) begin
            prod = (mag * x + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC;
            mag  = (prod + 64'(k >> 1)) / 64'(k);
         end
         if (k[0] == 1'b0) begin
            if (k[1]) cos_sum -= $signed(mag);
            else      cos_sum += $signed(mag);
         end else begin
            if (k[1]) sin_sum -= $signed(mag);
            else      sin_sum += $signed(mag);
         end
      end
      res.sine   = round_to_q8_16(sin_sum);
      res.cosine = round_to_q8_16(cos_sum);
      return res;
   endfunction

   // offer one request, idling at random beforehand, and record its result
   task automatic send_request(input logic [ANGLE_W-1:0] angle,
                               input logic [COUNT_W-1:0] terms,
                               input logic use_literal,
                               input trig_pair_type literal_pair);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - ANGLE_W - COUNT_W){1'b0}}, terms, angle};
      do @(posedge clock); while (!req_tready);
      trig_expected_q.push_back(use_literal ? literal_pair : taylor_sin_cos(angle, terms));
   endtask

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // run time limit
   initial begin
      #(TIMEOUT_NS);
      $display("end of test: mismatches");
      $finish;
   end

   // response side: random back-pressure and checking against the oldest request
   initial begin
      trig_pair_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (trig_expected_q.size() == 0) begin
               $error("unexpected response: sine_value %0d cosine_value %0d",
                      $signed(rsp_tdata[OUT_W-1:0]), $signed(rsp_tdata[2*OUT_W-1:OUT_W]));
               fail_count++;
            end else begin
               want = trig_expected_q.pop_front();
               if (rsp_tdata[OUT_W-1:0] !== want.sine) begin
                  $error("sine_value: expected %0d, actual %0d",
                         want.sine, $signed(rsp_tdata[OUT_W-1:0]));
                  fail_count++;
               end
               if (rsp_tdata[2*OUT_W-1:OUT_W] !== want.cosine) begin
                  $error("cosine_value: expected %0d, actual %0d",
                         want.cosine, $signed(rsp_tdata[2*OUT_W-1:OUT_W]));
                  fail_count++;
               end
            end
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 33);
      end
   end

   // request side: reset, directed table, random requests, drain
   initial begin
      logic [ANGLE_W-1:0] angle;
      logic [COUNT_W-1:0] terms;
      int unsigned        pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].angle, directed_rows[i].terms,
                      directed_rows[i].literal, directed_rows[i].pair);

      // hold off until the pipeline is empty
      req_tvalid <= 1'b0;
      do @(posedge clock); while (trig_expected_q.size() != 0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 250 && i < 400);
         // angles mostly around one turn, some over the full range, some corners
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            angle = ANGLE_W'($urandom_range(0, 400));
         end else if (pick < 9) begin
            angle = ANGLE_W'($urandom);
         end else begin
            case ($urandom_range(0, 3))
               0: angle = 16'd360;
               1: angle = 16'd361;
               2: angle = 16'd65535;
               default: angle = 16'd0;
            endcase
         end
         if ($urandom_range(0, 9) < 7) terms = COUNT_W'($urandom_range(0, 7));
         else                          terms = COUNT_W'($urandom_range(0, 15));
         send_request(angle, terms, 1'b0, '0);
      end
      steady = 1'b0;

      // drain and watch for stray responses
      req_tvalid <= 1'b0;
      while (trig_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### files.f
design/tsc_pkg.sv
design/tsc_front.sv
design/tsc_cell.sv
design/tsc_out.sv
design/taylor_sine_cosine_degrees.sv
design/tsc_checker.sv
bench/testbench.sv
